/* hw/rtl/dfrb_pkg.sv */
`default_nettype none
package dfrb_pkg;

	localparam int DEPTH_DEF        = 1024;
	localparam int LINEAR_DEPTH_DEF = 256;
	localparam int TERM_LEN         = 3;

	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int OFS_W  = 10;
	localparam int LEN_W  = 10;
	localparam int PEND_W = 16;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [PEND_W-1:0] PEND_MAX = 16'hFFFF;

	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_IDLE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FETCH = 2'd3;

	localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NONE     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TAKEN    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TERM_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_THIRD  = 2'd2;

	localparam logic [BYTE_W-1:0] TERM_FIRST_RST  = 8'd0;
	localparam logic [BYTE_W-1:0] TERM_SECOND_RST = 8'd127;
	localparam logic [BYTE_W-1:0] TERM_THIRD_RST  = 8'd255;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_IW    = $clog2(CQ_DEPTH);

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] rx_byte;
		logic [OFS_W-1:0]  fetch_offset;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} cq_t;

	typedef struct packed {
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] third;
	} term_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  frame_length;
		logic [LEN_W-1:0]  frame_start;
		logic [BYTE_W-1:0] byte_out;
		logic [PEND_W-1:0] frames_pending;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/delimited_frame_ring_buffer.sv */
// Flow: registered input queue, then S_IDLE answers a byte or a take with no frame;
//   idle: S_TERM; take: S_SCAN, one ring read per cycle, then S_TAKE; fetch: S_FMOD
//   per offset wrap, then S_FREAD. One word per pass, none while a result waits.
// Reset (arst_n, async): indexes, pending count and queues clear, terminators load
//   0/127/255; ring contents are not cleared.
`default_nettype none
module delimited_frame_ring_buffer import dfrb_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int LINEAR_DEPTH = LINEAR_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [CMD_W-1:0]     cmd,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic [OFS_W-1:0]     fetch_offset,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [STAT_W-1:0]         status,
	output logic [LEN_W-1:0]          frame_length,
	output logic [LEN_W-1:0]          frame_start,
	output logic [BYTE_W-1:0]         byte_out,
	output logic [PEND_W-1:0]         frames_pending,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_wdata
);

	item_t   item_in;
	cq_t     cq;
	logic    cq_pop;
	term_t   term_q;
	logic    res_valid;
	result_t res;

	assign item_in.cmd          = cmd;
	assign item_in.rx_byte      = rx_byte;
	assign item_in.fetch_offset = fetch_offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q.first  <= TERM_FIRST_RST;
			term_q.second <= TERM_SECOND_RST;
			term_q.third  <= TERM_THIRD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TERM_FIRST:  term_q.first  <= cfg_wdata;
				REG_TERM_SECOND: term_q.second <= cfg_wdata;
				REG_TERM_THIRD:  term_q.third  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dfrb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item_in (item_in),
		.cq      (cq),
		.cq_pop  (cq_pop)
	);

	dfrb_back #(
		.DEPTH        (DEPTH),
		.LINEAR_DEPTH (LINEAR_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq        (cq),
		.cq_pop    (cq_pop),
		.term      (term_q),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign empty          = !res_valid;
	assign status         = res.status;
	assign frame_length   = res.frame_length;
	assign frame_start    = res.frame_start;
	assign byte_out       = res.byte_out;
	assign frames_pending = res.frames_pending;

`ifndef SYNTHESIS
	a_none_means_zero_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STAT_NONE) |-> (frames_pending == '0))
		else $error("no-frame word with frames pending");

	a_frame_fields_only_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == STAT_ACCEPTED || status == STAT_NONE)) |->
		(frame_length == '0 && frame_start == '0))
		else $error("frame fields set outside a take");

	a_byte_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && byte_out != '0) |-> (status == STAT_ACCEPTED))
		else $error("fetched byte with a take status");
`endif

endmodule
`default_nettype wire

/* hw/rtl/dfrb_front.sv */
`default_nettype none
module dfrb_front import dfrb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t item_in,
	output cq_t        cq,
	input  wire logic  cq_pop
);

	item_t             slot_q [CQ_DEPTH];
	logic [CQ_IW-1:0]  wp_q;
	logic [CQ_IW-1:0]  rp_q;
	logic [CQ_IW:0]    cnt_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [CQ_IW-1:0] ptr_inc(input logic [CQ_IW-1:0] p);
		return (p == CQ_IW'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == (CQ_IW+1)'(CQ_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = cq_pop && (cnt_q != '0);
	assign cq.valid = (cnt_q != '0);
	assign cq.item  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (do_pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dfrb_back.sv */
`default_nettype none
module dfrb_back import dfrb_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int LINEAR_DEPTH = LINEAR_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cq_t   cq,
	output logic       cq_pop,
	input  wire term_t term,
	input  wire logic  res_pop,
	output logic       res_valid,
	output result_t    res
);

	localparam int IW = $clog2(DEPTH);
	localparam int AW = ((IW > OFS_W) ? IW : OFS_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [IW:0]   DEPTH_C  = (IW+1)'(DEPTH);
	localparam logic [AW-1:0] DEPTH_A  = AW'(DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TERM  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_TAKE  = 3'd3;
	localparam logic [2:0] S_FMOD  = 3'd4;
	localparam logic [2:0] S_FREAD = 3'd5;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] mem_rd_q;
	logic [IW-1:0]     rd_addr;
	logic              mem_we;
	logic [BYTE_W-1:0] mem_wd;

	logic [2:0]        state_q;
	logic [IW-1:0]     wr_idx_q;
	logic [IW-1:0]     rd_idx_q;
	logic [IW-1:0]     last_start_q;
	logic [PEND_W-1:0] pend_q;
	logic [1:0]        k_q;
	logic [IW-1:0]     pos_q;
	logic [1:0]        match_q;
	logic [IW:0]       cnt_q;
	logic [IW-1:0]     len_q;
	logic [AW-1:0]     acc_q;
	result_t           res_q;
	logic              res_valid_q;

	logic              go;
	logic [BYTE_W-1:0] term_k;
	logic [BYTE_W-1:0] term_m;
	logic [1:0]        match_n;
	logic [IW:0]       cnt_n;
	logic              scan_done;
	logic [IW:0]       sum;
	logic              too_long;
	logic [IW-1:0]     rd_next;
	logic [PEND_W-1:0] pend_inc;

	function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] v);
		return (v == LAST_IDX) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [BYTE_W-1:0] term_sel(input term_t t, input logic [1:0] k);
		logic [BYTE_W-1:0] b;
		case (k)
			2'd0:    b = t.first;
			2'd1:    b = t.second;
			default: b = t.third;
		endcase
		return b;
	endfunction

	function automatic result_t mk_res(
		input logic [STAT_W-1:0] st,
		input logic [LEN_W-1:0]  len,
		input logic [LEN_W-1:0]  start,
		input logic [BYTE_W-1:0] b,
		input logic [PEND_W-1:0] pend
	);
		result_t r;
		r.status         = st;
		r.frame_length   = len;
		r.frame_start    = start;
		r.byte_out       = b;
		r.frames_pending = pend;
		return r;
	endfunction

	assign go        = (state_q == S_IDLE) && cq.valid && !res_valid_q;
	assign cq_pop    = go;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign term_k = term_sel(term, k_q);
	assign term_m = term_sel(term, match_q);

	// terminator match, restart counts a fresh first byte
	always_comb begin
		if (mem_rd_q == term_m) begin
			match_n = match_q + 1'b1;
		end else if (mem_rd_q == term.first) begin
			match_n = 2'd1;
		end else begin
			match_n = 2'd0;
		end
	end

	assign cnt_n     = cnt_q + 1'b1;
	assign scan_done = (match_n == 2'(TERM_LEN)) || (cnt_n == DEPTH_C);

	assign sum      = {1'b0, rd_idx_q} + {1'b0, len_q};
	assign too_long = (wr_idx_q <= rd_idx_q) && (sum >= DEPTH_C) &&
	                  (32'(len_q) >= 32'(LINEAR_DEPTH));
	assign rd_next  = (sum >= DEPTH_C) ? IW'(sum - DEPTH_C) : sum[IW-1:0];
	assign pend_inc = (pend_q != PEND_MAX) ? pend_q + 1'b1 : pend_q;

	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_addr = pos_q;
			S_FMOD:  rd_addr = acc_q[IW-1:0];
			default: rd_addr = rd_idx_q;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = term_k;
		if (go && cq.item.cmd == CMD_BYTE) begin
			mem_we = 1'b1;
			mem_wd = cq.item.rx_byte;
		end else if (go && cq.item.cmd == CMD_IDLE) begin
			mem_we = 1'b1;
			mem_wd = term.first;
		end else if (state_q == S_TERM) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= mem_wd;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			last_start_q <= '0;
			pend_q       <= '0;
			k_q          <= '0;
			pos_q        <= '0;
			match_q      <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			acc_q        <= '0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						unique case (cq.item.cmd)
							CMD_BYTE: begin
								wr_idx_q    <= inc_wrap(wr_idx_q);
								res_q       <= mk_res(STAT_ACCEPTED, '0, '0, '0, pend_q);
								res_valid_q <= 1'b1;
							end
							CMD_IDLE: begin
								wr_idx_q <= inc_wrap(wr_idx_q);
								k_q      <= 2'd1;
								state_q  <= S_TERM;
							end
							CMD_TAKE: begin
								if (pend_q == '0) begin
									res_q       <= mk_res(STAT_NONE, '0, '0, '0, pend_q);
									res_valid_q <= 1'b1;
								end else begin
									pend_q  <= pend_q - 1'b1;
									pos_q   <= inc_wrap(rd_idx_q);
									match_q <= '0;
									cnt_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_FETCH: begin
								acc_q   <= AW'(last_start_q) + AW'(cq.item.fetch_offset);
								state_q <= S_FMOD;
							end
							default: ;
						endcase
					end
				end
				S_TERM: begin
					wr_idx_q <= inc_wrap(wr_idx_q);
					k_q      <= k_q + 1'b1;
					if (k_q == 2'(TERM_LEN - 1)) begin
						pend_q      <= pend_inc;
						res_q       <= mk_res(STAT_ACCEPTED, '0, '0, '0, pend_inc);
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					pos_q   <= inc_wrap(pos_q);
					match_q <= match_n;
					cnt_q   <= cnt_n;
					if (scan_done) begin
						len_q   <= (cnt_n == DEPTH_C) ? '0 : cnt_n[IW-1:0];
						state_q <= S_TAKE;
					end
				end
				S_TAKE: begin
					if (too_long) begin
						res_q <= mk_res(STAT_TOO_LONG, LEN_W'(len_q), LEN_W'(rd_idx_q),
							'0, pend_q);
					end else begin
						res_q <= mk_res(STAT_TAKEN, LEN_W'(len_q), LEN_W'(rd_idx_q),
							'0, pend_q);
						last_start_q <= rd_idx_q;
						rd_idx_q     <= rd_next;
					end
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FMOD: begin
					if (acc_q >= DEPTH_A) begin
						acc_q <= acc_q - DEPTH_A;
					end else begin
						state_q <= S_FREAD;
					end
				end
				S_FREAD: begin
					res_q       <= mk_res(STAT_ACCEPTED, '0, '0, mem_rd_q, pend_q);
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* tb/tb_delimited_frame_ring_buffer.sv */
`default_nettype none
module tb_delimited_frame_ring_buffer;
	import dfrb_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int PLAN_LEN    = 22;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [CMD_W-1:0]     cmd = CMD_BYTE;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic [OFS_W-1:0]     fetch_offset = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [LEN_W-1:0]     frame_length;
	logic [LEN_W-1:0]     frame_start;
	logic [BYTE_W-1:0]    byte_out;
	logic [PEND_W-1:0]    frames_pending;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TERM_FIRST;
	logic [BYTE_W-1:0]    cfg_wdata = '0;

	delimited_frame_ring_buffer u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.cmd(cmd), .rx_byte(rx_byte), .fetch_offset(fetch_offset),
		.empty(empty), .pop(pop),
		.status(status), .frame_length(frame_length), .frame_start(frame_start),
		.byte_out(byte_out), .frames_pending(frames_pending),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the buffer state
	logic [BYTE_W-1:0] ring_img [DEPTH_DEF];
	bit                ring_set [DEPTH_DEF];
	logic [LEN_W-1:0]  wr_ptr = '0;
	logic [LEN_W-1:0]  rd_ptr = '0;
	logic [LEN_W-1:0]  frame_base = '0;
	logic [PEND_W-1:0] pend_cnt = '0;
	term_t             terms = '{TERM_FIRST_RST, TERM_SECOND_RST, TERM_THIRD_RST};

	result_t expected_words [$];
	int      err_cnt = 0;
	int      n_sent = 0;
	int      rx_cyc = 0;
	bit      tx_quiet = 1'b0;
	bit      rx_quiet = 1'b0;
	bit      hold_req = 1'b0;

	typedef struct {
		logic [CMD_W-1:0]  c;
		logic [BYTE_W-1:0] b;
		logic [OFS_W-1:0]  o;
		bit                typed;
		result_t           want;
	} plan_row_t;

	plan_row_t plan [PLAN_LEN];

	function automatic logic [BYTE_W-1:0] term_at(input int k);
		if (k == 0)
			return terms.first;
		if (k == 1)
			return terms.second;
		return terms.third;
	endfunction

	function automatic void put_ring(input logic [BYTE_W-1:0] b);
		ring_img[wr_ptr] = b;
		ring_set[wr_ptr] = 1'b1;
		wr_ptr = LEN_W'((int'(wr_ptr) + 1) % DEPTH_DEF);
	endfunction

	// terminator search from the read pointer; blank flags a never-written entry
	function automatic void scan_ring(output int len, output bit blank);
		int pos;
		int hits;
		int cnt;
		logic [BYTE_W-1:0] b;
		pos = int'(rd_ptr);
		hits = 0;
		cnt = 0;
		blank = 1'b0;
		while (hits < TERM_LEN && cnt < DEPTH_DEF) begin
			if (!ring_set[pos])
				blank = 1'b1;
			b = ring_img[pos];
			if (b == term_at(hits))
				hits++;
			else
				hits = (b == terms.first) ? 1 : 0;
			cnt++;
			pos = (pos + 1) % DEPTH_DEF;
		end
		len = cnt % DEPTH_DEF;
	endfunction

	function automatic result_t buffer_step(input item_t it);
		result_t r;
		int len;
		bit blank;
		r = '0;
		r.status = STAT_ACCEPTED;
		case (it.cmd)
			CMD_BYTE: put_ring(it.rx_byte);
			CMD_IDLE: begin
				put_ring(terms.first);
				put_ring(terms.second);
				put_ring(terms.third);
				if (pend_cnt != PEND_MAX)
					pend_cnt++;
			end
			CMD_TAKE: begin
				if (pend_cnt == '0) begin
					r.status = STAT_NONE;
				end else begin
					pend_cnt--;
					scan_ring(len, blank);
					r.frame_length = LEN_W'(len);
					r.frame_start = rd_ptr;
					if (wr_ptr <= rd_ptr && int'(rd_ptr) + len >= DEPTH_DEF &&
							len >= LINEAR_DEPTH_DEF) begin
						r.status = STAT_TOO_LONG;
					end else begin
						r.status = STAT_TAKEN;
						frame_base = rd_ptr;
						rd_ptr = LEN_W'((int'(rd_ptr) + len) % DEPTH_DEF);
					end
				end
			end
			default: r.byte_out = ring_img[(int'(frame_base) + int'(it.fetch_offset)) % DEPTH_DEF];
		endcase
		r.frames_pending = pend_cnt;
		return r;
	endfunction

	function automatic bit word_is_safe(input logic [CMD_W-1:0] c, input logic [OFS_W-1:0] o);
		int len;
		bit blank;
		if (c == CMD_TAKE && pend_cnt != '0) begin
			scan_ring(len, blank);
			return !blank;
		end
		if (c == CMD_FETCH)
			return ring_set[(int'(frame_base) + int'(o)) % DEPTH_DEF];
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] content_byte();
		if ($urandom_range(0, 99) < 35)
			return term_at($urandom_range(0, 2));
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
			input logic [OFS_W-1:0] o, input bit typed = 1'b0, input result_t want = '0);
		item_t it;
		result_t r;
		int g;
		// never let a take or fetch touch an unwritten ring entry
		if (!word_is_safe(c, o))
			c = CMD_BYTE;
		g = (tx_quiet || (n_sent / 64) % 5 == 4) ? 0 : pick_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd <= c;
		rx_byte <= b;
		fetch_offset <= o;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		it.cmd = c;
		it.rx_byte = b;
		it.fetch_offset = o;
		r = buffer_step(it);
		expected_words.push_back(typed ? want : r);
		n_sent++;
	endtask

	task automatic send_rand(input logic [CMD_W-1:0] c, input int ofs_hi = 1023);
		send_word(c, BYTE_W'($urandom_range(0, 255)), OFS_W'($urandom_range(0, ofs_hi)));
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_terms(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_index <= REG_TERM_FIRST;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_index <= REG_TERM_SECOND;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_index <= REG_TERM_THIRD;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		terms = '{a, b, c};
	endtask

	// one frame: content, idle, then usually a take and a few fetches
	task automatic send_frame(input int len, input bit plain);
		int k;
		for (k = 0; k < len; k++)
			send_word(CMD_BYTE, plain ? BYTE_W'($urandom_range(0, 255)) : content_byte(),
				OFS_W'($urandom_range(0, 1023)));
		send_rand(CMD_IDLE);
		if (plain || $urandom_range(0, 99) < 75) begin
			send_rand(CMD_TAKE);
			repeat ($urandom_range(0, 2))
				send_rand(CMD_FETCH, ($urandom_range(0, 9) == 0) ? 1023 : len + 2);
		end
	endtask

	task automatic random_phase(input int quota);
		int stop;
		stop = n_sent + quota;
		while (n_sent < stop) begin
			if ($urandom_range(0, 99) < 70)
				send_frame(($urandom_range(0, 99) < 2) ? $urandom_range(200, 280) :
					$urandom_range(0, 12), 1'b0);
			else
				send_rand(CMD_W'($urandom_range(0, 3)));
		end
	endtask

	// result side
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !rx_quiet && (rx_cyc / 300) % 4 != 3 &&
					$urandom_range(0, 99) < 30) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
			rx_cyc++;
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && pop && !empty) begin
			got = '{status, frame_length, frame_start, byte_out, frames_pending};
			if (expected_words.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 20)
					$display("%0t: unexpected word st %0d len %0d start %0d byte %0h pend %0d",
						$time, got.status, got.frame_length, got.frame_start, got.byte_out,
						got.frames_pending);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= 20)
						$display({"%0t: mismatch exp/got st %0d/%0d len %0d/%0d start %0d/%0d",
							" byte %0h/%0h pend %0d/%0d"}, $time,
							want.status, got.status, want.frame_length, got.frame_length,
							want.frame_start, got.frame_start, want.byte_out, got.byte_out,
							want.frames_pending, got.frames_pending);
				end
			end
		end
	end

	initial begin
		#400000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int p;
		int k;
		plan = '{
			'{CMD_TAKE,  8'hFF, 10'd1023, 1'b1, '{STAT_NONE, 10'd0, 10'd0, 8'h00, 16'd0}},
			'{CMD_BYTE,  8'h00, 10'd0,    1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd0}},
			'{CMD_BYTE,  8'hFF, 10'd512,  1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd0}},
			'{CMD_BYTE,  8'h7F, 10'd0,    1'b0, '0},
			'{CMD_BYTE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_BYTE,  8'h7F, 10'd0,    1'b0, '0},
			'{CMD_BYTE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_IDLE,  8'hFF, 10'd1023, 1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd1}},
			'{CMD_FETCH, 8'hFF, 10'd0,    1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd1}},
			// restart on mismatch, a stray first byte counts as a new first match
			'{CMD_TAKE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_FETCH, 8'h00, 10'd8,    1'b0, '0},
			'{CMD_IDLE,  8'h00, 10'd0,    1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd1}},
			'{CMD_IDLE,  8'h00, 10'd0,    1'b1, '{STAT_ACCEPTED, 10'd0, 10'd0, 8'h00, 16'd2}},
			'{CMD_TAKE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_TAKE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_TAKE,  8'h00, 10'd0,    1'b1, '{STAT_NONE, 10'd0, 10'd0, 8'h00, 16'd0}},
			'{CMD_FETCH, 8'h00, 10'd2,    1'b0, '0},
			'{CMD_BYTE,  8'hAA, 10'd341,  1'b0, '0},
			'{CMD_BYTE,  8'h55, 10'd682,  1'b0, '0},
			'{CMD_IDLE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_TAKE,  8'h00, 10'd0,    1'b0, '0},
			'{CMD_FETCH, 8'h00, 10'd4,    1'b0, '0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_word(plan[i].c, plan[i].b, plan[i].o, plan[i].typed, plan[i].want);
		drain();

		// long frames until the write side wraps; the last one wraps past the end
		for (k = 0; k < 4; k++)
			send_frame($urandom_range(260, 320), 1'b1);

		for (p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: write_terms(8'hFF, 8'hFF, 8'hFF);
				1: write_terms(8'h00, 8'h00, 8'h00);
				default: write_terms(BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
			endcase
			if (p == 0)
				hold_req = 1'b1;
			random_phase(80);
		end

		// back-to-back tail with both sides open
		drain();
		write_terms(8'h0D, 8'h0A, 8'h00);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		send_rand(CMD_TAKE);
		send_rand(CMD_IDLE);
		send_rand(CMD_IDLE);
		send_rand(CMD_TAKE);
		send_rand(CMD_FETCH);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		drain();
		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/dfrb_pkg.sv
hw/rtl/dfrb_front.sv
hw/rtl/dfrb_back.sv
hw/rtl/delimited_frame_ring_buffer.sv
tb/tb_delimited_frame_ring_buffer.sv
